[hdl/brod_pkg.sv]
// ---------------------------------------------------------------------------
// brod_pkg
// Shared widths, constants, register indexes and types of the band run
// onset detector.
// ---------------------------------------------------------------------------
package brod_pkg;

    localparam int DATA_W        = 16;
    localparam int CNT_W         = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int OUTCOME_W     = 2;
    localparam int PATTERN_DEPTH = 6;
    localparam int QUEUE_DEPTH   = 2;

    // completed run count only matters up to this value
    localparam int RUNS_W   = 4;
    localparam int RUNS_SAT = PATTERN_DEPTH + 2;

    // four run lengths summed, and that sum plus one more
    localparam int SUM4_W = CNT_W + 2;
    localparam int TAIL_W = CNT_W + 3;

    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [DATA_W-1:0] INDEX_MAX = {DATA_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_RUN_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_MAX    = 3'd3;

    // configuration reset values
    localparam logic [DATA_W-1:0] RST_BAND_LOW     = 16'd77;
    localparam logic [DATA_W-1:0] RST_BAND_HIGH    = 16'd384;
    localparam logic [DATA_W-1:0] RST_LONG_RUN_MIN = 16'd50;
    localparam logic [DATA_W-1:0] RST_NOISE_MAX    = 16'd10;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_FOUND    = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NO_MATCH = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NO_RUNS  = 2'd2;

    // classified sample handed from front to back
    typedef struct packed {
        logic in_band;
        logic last;
    } t_q_item;

    // pattern thresholds used by the back part
    typedef struct packed {
        logic [DATA_W-1:0] long_run_min;
        logic [DATA_W-1:0] noise_max;
    } t_back_cfg;

endpackage

[hdl/band_run_onset_detector.sv]
// ---------------------------------------------------------------------------
// band_run_onset_detector
// Finds the onset of an in-band run after a long out-of-band run in a
// record of signed Q8.8 samples.
// ---------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_ready carries one sample per item with
//   i_last_sample marking the end of a record. output channel o_out_valid /
//   i_out_ready carries one result per record: o_onset_index and o_outcome
//   (found, no match, no completed runs).
//   config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (band_low, band_high, long_run_min, noise_max); other indexes are ignored.
//   Write it only while the block is idle.
// Timing:
//   one sample per cycle while o_in_ready is high. the front classifies the
//   sample into a two-entry queue; the back part takes one queue entry per
//   cycle and registers the result of the last sample on o_out_valid.
//   when the receiver stalls, the result register holds and samples keep
//   flowing until the next final sample, which waits in the queue; the queue
//   then fills and o_in_ready falls.
// Reset:
//   synchronous, active low: registers return to their defaults, the record
//   state clears and the queue empties.
// ---------------------------------------------------------------------------
module band_run_onset_detector #(
    parameter int QUEUE_DEPTH = brod_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [brod_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [brod_pkg::DATA_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [brod_pkg::DATA_W-1:0]     i_sample_value,
    input  logic                                   i_last_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [brod_pkg::DATA_W-1:0]            o_onset_index,
    output logic [brod_pkg::OUTCOME_W-1:0]         o_outcome
);

    logic [brod_pkg::DATA_W-1:0] r_band_low;
    logic [brod_pkg::DATA_W-1:0] r_band_high;
    logic [brod_pkg::DATA_W-1:0] r_long_run_min;
    logic [brod_pkg::DATA_W-1:0] r_noise_max;

    brod_pkg::t_back_cfg back_cfg;
    brod_pkg::t_q_item   push_item;
    brod_pkg::t_q_item   pop_item;
    logic                push_valid;
    logic                push_ready;
    logic                pop_valid;
    logic                pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low     <= brod_pkg::RST_BAND_LOW;
            r_band_high    <= brod_pkg::RST_BAND_HIGH;
            r_long_run_min <= brod_pkg::RST_LONG_RUN_MIN;
            r_noise_max    <= brod_pkg::RST_NOISE_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brod_pkg::REG_BAND_LOW:     r_band_low     <= i_cfg_data;
                brod_pkg::REG_BAND_HIGH:    r_band_high    <= i_cfg_data;
                brod_pkg::REG_LONG_RUN_MIN: r_long_run_min <= i_cfg_data;
                brod_pkg::REG_NOISE_MAX:    r_noise_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign back_cfg.long_run_min = r_long_run_min;
    assign back_cfg.noise_max    = r_noise_max;

    brod_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_last_sample  (i_last_sample),
        .i_band_low     ($signed(r_band_low)),
        .i_band_high    ($signed(r_band_high)),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_item    (push_item)
    );

    brod_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    brod_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (back_cfg),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_item    (pop_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_onset_index (o_onset_index),
        .o_outcome     (o_outcome)
    );

endmodule

[hdl/brod_front.sv]
// ---------------------------------------------------------------------------
// brod_front
// Accepts samples and classifies each one as in-band or out-of-band
// against the exclusive signed bounds.
// ---------------------------------------------------------------------------
module brod_front (
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [brod_pkg::DATA_W-1:0] i_sample_value,
    input  logic                              i_last_sample,
    input  logic signed [brod_pkg::DATA_W-1:0] i_band_low,
    input  logic signed [brod_pkg::DATA_W-1:0] i_band_high,
    output logic                              o_push_valid,
    input  logic                              i_push_ready,
    output brod_pkg::t_q_item                 o_push_item
);

    logic in_band;

    // an empty or inverted band never matches
    assign in_band = (i_sample_value > i_band_low) && (i_sample_value < i_band_high);

    assign o_in_ready           = i_push_ready;
    assign o_push_valid         = i_in_valid;
    assign o_push_item.in_band  = in_band;
    assign o_push_item.last     = i_last_sample;

endmodule

[hdl/brod_queue.sv]
// ---------------------------------------------------------------------------
// brod_queue
// Small first-in first-out queue of classified samples between the front
// and the back part.
// ---------------------------------------------------------------------------
module brod_queue #(
    parameter int DEPTH = brod_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  brod_pkg::t_q_item i_push_item,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output brod_pkg::t_q_item o_pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    brod_pkg::t_q_item r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[hdl/brod_back.sv]
// ---------------------------------------------------------------------------
// brod_back
// Run-length encodes classified samples, tests the window of completed runs
// for an onset pattern and registers the per-record result.
// ---------------------------------------------------------------------------
module brod_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  brod_pkg::t_back_cfg                  i_cfg,
    input  logic                                 i_pop_valid,
    output logic                                 o_pop_ready,
    input  brod_pkg::t_q_item                    i_pop_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [brod_pkg::DATA_W-1:0]          o_onset_index,
    output logic [brod_pkg::OUTCOME_W-1:0]       o_outcome
);

    localparam int CW = brod_pkg::CNT_W;
    localparam int PD = brod_pkg::PATTERN_DEPTH;
    localparam int RW = brod_pkg::RUNS_W;
    localparam int SW = brod_pkg::SUM4_W;
    localparam int TW = brod_pkg::TAIL_W;
    localparam int DW = brod_pkg::DATA_W;
    localparam logic [RW-1:0] RUNS_SAT = RW'(brod_pkg::RUNS_SAT);

    logic          r_started;
    logic          r_phase;
    logic [CW-1:0] r_cur;
    logic [RW-1:0] r_runs;
    logic [CW-1:0] r_win [PD];
    logic [CW-1:0] r_prefix;
    logic [SW-1:0] r_sum4;
    logic          r_latched;
    logic [DW-1:0] r_lidx;

    logic                          r_out_valid;
    logic [DW-1:0]                 r_onset;
    logic [brod_pkg::OUTCOME_W-1:0] r_outcome;

    logic          pop;
    logic          inb;
    logic          comp;
    logic          kind;
    logic [CW-1:0] len;
    logic          n_phase;
    logic [CW-1:0] n_cur;
    logic [RW-1:0] n_runs;
    logic [CW-1:0] n_win [PD];
    logic [CW:0]   psum;
    logic [CW-1:0] n_prefix;
    logic [SW-1:0] n_sum4;
    logic [TW-1:0] tail;
    logic [TW-1:0] pref_ext;
    logic [TW-1:0] diff;
    logic [DW-1:0] idx;
    logic [CW-1:0] lim_l;
    logic [CW-1:0] lim_n;
    logic          hit;
    logic          n_latched;
    logic [DW-1:0] n_lidx;
    logic [brod_pkg::OUTCOME_W-1:0] res_outcome;
    logic [DW-1:0] res_index;

    // a non-final sample never touches the output register
    assign o_pop_ready = !i_pop_item.last || !r_out_valid || i_out_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign inb         = i_pop_item.in_band;

    assign lim_l = CW'(i_cfg.long_run_min);
    assign lim_n = CW'(i_cfg.noise_max);

    always_comb begin
        comp    = 1'b0;
        kind    = 1'b0;
        len     = '0;
        n_phase = r_phase;
        n_cur   = r_cur;
        if (!r_started && inb) begin
            // record opens in-band: empty out-of-band run completes first
            comp    = 1'b1;
            n_phase = 1'b1;
            n_cur   = CW'(1);
        end else if (inb == r_phase) begin
            n_cur = (r_cur == brod_pkg::CNT_MAX) ? r_cur : r_cur + CW'(1);
        end else begin
            comp    = 1'b1;
            kind    = r_phase;
            len     = r_cur;
            n_phase = !r_phase;
            n_cur   = CW'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < PD - 1; k++) begin
            n_win[k] = r_win[k + 1];
        end
        n_win[PD-1] = len;
    end

    assign psum     = {1'b0, r_prefix} + {1'b0, len};
    assign n_prefix = psum[CW] ? brod_pkg::CNT_MAX : psum[CW-1:0];
    assign n_sum4   = r_sum4 - SW'(r_win[2]) + SW'(len);
    assign n_runs   = (r_runs == RUNS_SAT) ? r_runs : r_runs + RW'(1);

    // onset index is the prefix through the long run: total minus the five after it
    assign tail     = TW'(r_sum4) + TW'(len);
    assign pref_ext = TW'(n_prefix);
    assign diff     = (pref_ext > tail) ? pref_ext - tail : '0;
    assign idx      = (diff > TW'(brod_pkg::INDEX_MAX)) ? brod_pkg::INDEX_MAX : diff[DW-1:0];

    // window after the shift: n_win[0..5]
    assign hit = (n_win[0] > lim_l) &&
                 ((n_win[1] >= lim_n) ||
                  ((n_win[2] < lim_n) &&
                   ((n_win[3] > lim_n) || ((n_win[4] < lim_n) && (n_win[5] > lim_n)))));

    always_comb begin
        n_latched = r_latched;
        n_lidx    = r_lidx;
        if (comp && kind && (n_runs == RUNS_SAT) && !r_latched && hit) begin
            n_latched = 1'b1;
            n_lidx    = idx;
        end
    end

    always_comb begin
        res_index = '0;
        if ((comp ? n_runs : r_runs) == '0) begin
            res_outcome = brod_pkg::OUTCOME_NO_RUNS;
        end else if (n_latched) begin
            res_outcome = brod_pkg::OUTCOME_FOUND;
            res_index   = n_lidx;
        end else begin
            res_outcome = brod_pkg::OUTCOME_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_phase   <= 1'b0;
            r_cur     <= '0;
            r_runs    <= '0;
            r_prefix  <= '0;
            r_sum4    <= '0;
            r_latched <= 1'b0;
            r_lidx    <= '0;
            for (int k = 0; k < PD; k++) begin
                r_win[k] <= '0;
            end
        end else if (pop) begin
            if (i_pop_item.last) begin
                r_started <= 1'b0;
                r_phase   <= 1'b0;
                r_cur     <= '0;
                r_runs    <= '0;
                r_prefix  <= '0;
                r_sum4    <= '0;
                r_latched <= 1'b0;
                r_lidx    <= '0;
                for (int k = 0; k < PD; k++) begin
                    r_win[k] <= '0;
                end
            end else begin
                r_started <= 1'b1;
                r_phase   <= n_phase;
                r_cur     <= n_cur;
                r_latched <= n_latched;
                r_lidx    <= n_lidx;
                if (comp) begin
                    r_runs   <= n_runs;
                    r_prefix <= n_prefix;
                    r_sum4   <= n_sum4;
                    for (int k = 0; k < PD; k++) begin
                        r_win[k] <= n_win[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_pop_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_item.last) begin
            r_onset   <= res_index;
            r_outcome <= res_outcome;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_onset_index = r_onset;
    assign o_outcome     = r_outcome;

endmodule
